// File: src/dcma_pkg.sv
// Shared constants, types and controller encodings for the dual-class moving average.
package dcma_pkg;

    localparam int DATE_W            = 27;
    localparam int VAL_W             = 16;
    localparam int LEN_W             = 6;
    // 16-bit values summed over at most 63 entries
    localparam int SUM_W             = VAL_W + LEN_W;
    localparam int DIV_CNT_W         = $clog2(SUM_W);
    localparam int WINDOW_MAX_DEFAULT = 32;
    localparam logic [LEN_W-1:0] WIN_LEN_RESET = LEN_W'(5);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_DIVIDE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic latch_in;
        logic ram_rd;
        logic update;
        logic div_start;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic emit;
        logic div_last;
        logic out_free;
    } status_t;

endpackage

// File: src/dcma_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dcma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/dcma_datapath.sv
// Datapath: class state, window RAM, running sums, shift-subtract divider, output word.
module dcma_datapath #(
    parameter int WINDOW_MAX = dcma_pkg::WINDOW_MAX_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  dcma_pkg::cmd_t               cmd,
    output dcma_pkg::status_t            status,
    input  logic [dcma_pkg::DATE_W-1:0]  s_date_tag,
    input  logic                         s_is_close,
    input  logic [dcma_pkg::VAL_W-1:0]   s_value_a,
    input  logic [dcma_pkg::VAL_W-1:0]   s_value_b,
    input  logic                         cfg_valid,
    input  logic [dcma_pkg::LEN_W-1:0]   cfg_window_len,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [dcma_pkg::DATE_W-1:0]  m_out_date,
    output logic                         m_out_is_close,
    output logic [dcma_pkg::VAL_W-1:0]   m_avg_a,
    output logic [dcma_pkg::VAL_W-1:0]   m_avg_b
);

    localparam int PTR_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CMP_W  = ((PTR_W > dcma_pkg::LEN_W) ? PTR_W : dcma_pkg::LEN_W) + 1;
    localparam int ADDR_W = PTR_W + 1;
    localparam int RAM_DEPTH = 2 ** ADDR_W;
    localparam int LEN_W  = dcma_pkg::LEN_W;
    localparam int SUM_W  = dcma_pkg::SUM_W;
    localparam int VAL_W  = dcma_pkg::VAL_W;

    logic [LEN_W-1:0]           win_len_reg;
    logic [SUM_W-1:0]           sum_a_reg [2];
    logic [SUM_W-1:0]           sum_b_reg [2];
    logic [LEN_W-1:0]           fill_reg  [2];
    logic [PTR_W-1:0]           ptr_reg   [2];

    logic [dcma_pkg::DATE_W-1:0] date_reg;
    logic                        cls_reg;
    logic [VAL_W-1:0]            a_reg;
    logic [VAL_W-1:0]            b_reg;

    logic [LEN_W-1:0]           rem_a_reg, rem_a_next;
    logic [LEN_W-1:0]           rem_b_reg, rem_b_next;
    logic [SUM_W-1:0]           quo_a_reg, quo_a_next;
    logic [SUM_W-1:0]           quo_b_reg, quo_b_next;
    logic [dcma_pkg::DIV_CNT_W-1:0] div_cnt_reg;

    logic                        out_valid_reg;
    logic [dcma_pkg::DATE_W-1:0] out_date_reg;
    logic                        out_cls_reg;
    logic [VAL_W-1:0]            out_a_reg;
    logic [VAL_W-1:0]            out_b_reg;

    logic [LEN_W-1:0]  m_eff;
    logic [PTR_W-1:0]  p_cur;
    logic [CMP_W-1:0]  p_inc;
    logic [PTR_W-1:0]  ptr_next;
    logic              full;
    logic [LEN_W-1:0]  fill_next;
    logic [SUM_W-1:0]  sum_a_new;
    logic [SUM_W-1:0]  sum_b_new;
    logic [2*VAL_W-1:0] rd_data;
    logic [ADDR_W-1:0] ram_addr;
    logic [LEN_W:0]    trial_a;
    logic [LEN_W:0]    trial_b;

    // effective window: zero acts as one, saturate at WINDOW_MAX
    always_comb begin
        if (win_len_reg == '0) begin
            m_eff = LEN_W'(1);
        end else if (CMP_W'(win_len_reg) > CMP_W'(WINDOW_MAX)) begin
            m_eff = LEN_W'(WINDOW_MAX);
        end else begin
            m_eff = win_len_reg;
        end
    end

    always_comb begin
        if (CMP_W'(ptr_reg[cls_reg]) >= CMP_W'(m_eff)) begin
            p_cur = '0;
        end else begin
            p_cur = ptr_reg[cls_reg];
        end
        p_inc = CMP_W'(p_cur) + CMP_W'(1);
        if (p_inc >= CMP_W'(m_eff)) begin
            ptr_next = '0;
        end else begin
            ptr_next = PTR_W'(p_inc);
        end
        full      = (fill_reg[cls_reg] >= m_eff);
        fill_next = full ? m_eff : fill_reg[cls_reg] + LEN_W'(1);
        sum_a_new = sum_a_reg[cls_reg]
                  - (full ? SUM_W'(rd_data[VAL_W-1:0]) : '0) + SUM_W'(a_reg);
        sum_b_new = sum_b_reg[cls_reg]
                  - (full ? SUM_W'(rd_data[2*VAL_W-1:VAL_W]) : '0) + SUM_W'(b_reg);
    end

    assign ram_addr = {cls_reg, p_cur};

    dcma_ram #(
        .WIDTH (2 * VAL_W),
        .DEPTH (RAM_DEPTH)
    ) u_window_ram (
        .aclk    (aclk),
        .wr_en   (cmd.update),
        .wr_addr (ram_addr),
        .wr_data ({b_reg, a_reg}),
        .rd_en   (cmd.ram_rd),
        .rd_addr (ram_addr),
        .rd_data (rd_data)
    );

    // one restoring step per cycle for both sums
    always_comb begin
        trial_a = {rem_a_reg, quo_a_reg[SUM_W-1]};
        trial_b = {rem_b_reg, quo_b_reg[SUM_W-1]};
        if (trial_a >= {1'b0, m_eff}) begin
            rem_a_next = LEN_W'(trial_a - {1'b0, m_eff});
            quo_a_next = {quo_a_reg[SUM_W-2:0], 1'b1};
        end else begin
            rem_a_next = LEN_W'(trial_a);
            quo_a_next = {quo_a_reg[SUM_W-2:0], 1'b0};
        end
        if (trial_b >= {1'b0, m_eff}) begin
            rem_b_next = LEN_W'(trial_b - {1'b0, m_eff});
            quo_b_next = {quo_b_reg[SUM_W-2:0], 1'b1};
        end else begin
            rem_b_next = LEN_W'(trial_b);
            quo_b_next = {quo_b_reg[SUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_len_reg <= dcma_pkg::WIN_LEN_RESET;
            for (int i = 0; i < 2; i++) begin
                sum_a_reg[i] <= '0;
                sum_b_reg[i] <= '0;
                fill_reg[i]  <= '0;
                ptr_reg[i]   <= '0;
            end
        end else if (cfg_valid) begin
            // new window length empties both classes
            win_len_reg <= cfg_window_len;
            for (int i = 0; i < 2; i++) begin
                sum_a_reg[i] <= '0;
                sum_b_reg[i] <= '0;
                fill_reg[i]  <= '0;
                ptr_reg[i]   <= '0;
            end
        end else if (cmd.update) begin
            sum_a_reg[cls_reg] <= sum_a_new;
            sum_b_reg[cls_reg] <= sum_b_new;
            fill_reg[cls_reg]  <= fill_next;
            ptr_reg[cls_reg]   <= ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            date_reg <= s_date_tag;
            cls_reg  <= s_is_close;
            a_reg    <= s_value_a;
            b_reg    <= s_value_b;
        end
        if (cmd.div_start) begin
            rem_a_reg <= '0;
            rem_b_reg <= '0;
            quo_a_reg <= sum_a_new;
            quo_b_reg <= sum_b_new;
        end else if (cmd.div_step) begin
            rem_a_reg <= rem_a_next;
            rem_b_reg <= rem_b_next;
            quo_a_reg <= quo_a_next;
            quo_b_reg <= quo_b_next;
        end
        if (cmd.out_load) begin
            out_date_reg <= date_reg;
            out_cls_reg  <= cls_reg;
            out_a_reg    <= quo_a_reg[VAL_W-1:0];
            out_b_reg    <= quo_b_reg[VAL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.div_start) begin
                div_cnt_reg <= '0;
            end else if (cmd.div_step) begin
                div_cnt_reg <= div_cnt_reg + dcma_pkg::DIV_CNT_W'(1);
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.emit     = (fill_next >= m_eff);
    assign status.div_last = (div_cnt_reg == dcma_pkg::DIV_CNT_W'(SUM_W - 1));
    assign status.out_free = !out_valid_reg || m_ready;

    assign m_valid        = out_valid_reg;
    assign m_out_date     = out_date_reg;
    assign m_out_is_close = out_cls_reg;
    assign m_avg_a        = out_a_reg;
    assign m_avg_b        = out_b_reg;

endmodule

// File: src/dcma_ctrl.sv
// Controller: sequences read, update, divide and output load for one word at a time.
module dcma_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  dcma_pkg::status_t status,
    output dcma_pkg::cmd_t    cmd
);

    dcma_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dcma_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dcma_pkg::ST_IDLE: begin
                if (s_valid) state_next = dcma_pkg::ST_READ;
            end
            dcma_pkg::ST_READ:   state_next = dcma_pkg::ST_UPDATE;
            dcma_pkg::ST_UPDATE: begin
                state_next = status.emit ? dcma_pkg::ST_DIVIDE : dcma_pkg::ST_IDLE;
            end
            dcma_pkg::ST_DIVIDE: begin
                if (status.div_last) state_next = dcma_pkg::ST_DONE;
            end
            dcma_pkg::ST_DONE: begin
                if (status.out_free) state_next = dcma_pkg::ST_IDLE;
            end
            default: state_next = dcma_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            dcma_pkg::ST_IDLE: begin
                s_ready      = 1'b1;
                cmd.latch_in = s_valid;
            end
            dcma_pkg::ST_READ:   cmd.ram_rd = 1'b1;
            dcma_pkg::ST_UPDATE: begin
                cmd.update    = 1'b1;
                cmd.div_start = status.emit;
            end
            dcma_pkg::ST_DIVIDE: cmd.div_step = 1'b1;
            dcma_pkg::ST_DONE:   cmd.out_load = status.out_free;
            default: begin
                cmd     = '0;
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: src/dual_class_moving_average_core.sv
// A word that yields an average goes through read, update, the bit-serial divider (one
// quotient bit per cycle) and output load, which waits until the output register is free.
// Other words return to idle after update; only one word is in flight at a time.
// The output register holds a finished average while the next word is taken in.
// Reset (aresetn low, synchronous): window length 5, sums, fills and ring pointers zero.
// cfg writes are taken in any cycle and empty both classes.
module dual_class_moving_average_core #(
    parameter int WINDOW_MAX = dcma_pkg::WINDOW_MAX_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [dcma_pkg::DATE_W-1:0]  s_date_tag,
    input  logic                         s_is_close,
    input  logic [dcma_pkg::VAL_W-1:0]   s_value_a,
    input  logic [dcma_pkg::VAL_W-1:0]   s_value_b,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [dcma_pkg::LEN_W-1:0]   cfg_window_len,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [dcma_pkg::DATE_W-1:0]  m_out_date,
    output logic                         m_out_is_close,
    output logic [dcma_pkg::VAL_W-1:0]   m_avg_a,
    output logic [dcma_pkg::VAL_W-1:0]   m_avg_b
);

    dcma_pkg::cmd_t    cmd;
    dcma_pkg::status_t status;

    assign cfg_ready = 1'b1;

    dcma_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    dcma_datapath #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_date_tag     (s_date_tag),
        .s_is_close     (s_is_close),
        .s_value_a      (s_value_a),
        .s_value_b      (s_value_b),
        .cfg_valid      (cfg_valid),
        .cfg_window_len (cfg_window_len),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_date     (m_out_date),
        .m_out_is_close (m_out_is_close),
        .m_avg_a        (m_avg_a),
        .m_avg_b        (m_avg_b)
    );

endmodule

// File: src/dcma_checker.sv
// Port-level checker for the moving average core, bound to the top level.
module dcma_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [dcma_pkg::DATE_W-1:0]  m_out_date,
    input logic                         m_out_is_close,
    input logic [dcma_pkg::VAL_W-1:0]   m_avg_a,
    input logic [dcma_pkg::VAL_W-1:0]   m_avg_b
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_date) && $stable(m_out_is_close)
            && $stable(m_avg_a) && $stable(m_avg_b))
        else $error("result word changed while stalled");

    // one word in flight: busy right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while previous word in flight");

    // the read and sum update states lie between an accept and any new result
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid) ##1 !$rose(m_valid))
        else $error("result appeared too soon after accept");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

endmodule

bind dual_class_moving_average_core dcma_checker u_dcma_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_out_date     (m_out_date),
    .m_out_is_close (m_out_is_close),
    .m_avg_a        (m_avg_a),
    .m_avg_b        (m_avg_b)
);
